FILE: hw/rtl/gcd_pkg.sv
// Shared constants and the arctangent table for the great-circle distance pipeline.
`default_nettype none
package gcd_pkg;
	localparam int XW = 34;
	localparam int SQW = 61;
	localparam int SQRT_STEPS = 31;
	localparam int LANES = 4;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint Q30_PI = 64'sd3373259426;
	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam logic signed [XW-1:0] Q30_GAIN = 34'sd652032874;
	localparam logic signed [31:0] DEG2RAD_Q36 = 32'sd1199381129;
	localparam logic [25:0] DIST_MAX = 26'h3ffffff;
	localparam logic [15:0] RADIUS_RST = 16'd6371;

	function automatic longint atan_q30(input int i);
		longint r;
		case (i)
			0: r = 843314857;
			1: r = 497837829;
			2: r = 263043837;
			3: r = 133525159;
			4: r = 67021687;
			5: r = 33543516;
			6: r = 16775851;
			7: r = 8388437;
			8: r = 4194283;
			9: r = 2097149;
			10: r = 1048576;
			11: r = 524288;
			12: r = 262144;
			13: r = 131072;
			14: r = 65536;
			15: r = 32768;
			16: r = 16384;
			17: r = 8192;
			18: r = 4096;
			19: r = 2048;
			20: r = 1024;
			21: r = 512;
			22: r = 256;
			23: r = 128;
			24: r = 64;
			25: r = 32;
			26: r = 16;
			27: r = 8;
			28: r = 4;
			29: r = 2;
			30: r = 1;
			31: r = 1;
			default: r = 0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/gcd_rot_cell.sv
// One rotation-mode CORDIC cell of the sine/cosine chain.
`default_nettype none
module gcd_rot_cell #(
	parameter int STAGE = 0,
	parameter int ZW = 34
) (
	input  logic                         clk,
	input  logic signed [gcd_pkg::XW-1:0] x_i,
	input  logic signed [gcd_pkg::XW-1:0] y_i,
	input  logic signed [ZW-1:0]          z_i,
	input  logic                         neg_i,
	output logic signed [gcd_pkg::XW-1:0] x_q,
	output logic signed [gcd_pkg::XW-1:0] y_q,
	output logic signed [ZW-1:0]          z_q,
	output logic                         neg_q
);
	import gcd_pkg::*;

	localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(STAGE));

	always_ff @(posedge clk) begin
		neg_q <= neg_i;
		if (!z_i[ZW-1]) begin
			x_q <= x_i - (y_i >>> STAGE);
			y_q <= y_i + (x_i >>> STAGE);
			z_q <= z_i - ANG;
		end else begin
			x_q <= x_i + (y_i >>> STAGE);
			y_q <= y_i - (x_i >>> STAGE);
			z_q <= z_i + ANG;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/gcd_sqrt_cell.sv
// One digit step of the pipelined integer square root.
`default_nettype none
module gcd_sqrt_cell #(
	parameter int K = 0
) (
	input  logic                     clk,
	input  logic [gcd_pkg::SQW-1:0] v_i,
	input  logic [gcd_pkg::SQW-1:0] r_i,
	output logic [gcd_pkg::SQW-1:0] v_q,
	output logic [gcd_pkg::SQW-1:0] r_q
);
	import gcd_pkg::*;

	localparam logic [SQW:0] BIT = (SQW+1)'(1) << (SQW - 1 - 2 * K);

	logic [SQW:0] sum;
	assign sum = {1'b0, r_i} + BIT;

	always_ff @(posedge clk) begin
		if ({1'b0, v_i} >= sum) begin
			v_q <= v_i - sum[SQW-1:0];
			r_q <= (r_i >> 1) + BIT[SQW-1:0];
		end else begin
			v_q <= v_i;
			r_q <= r_i >> 1;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/gcd_vec_cell.sv
// One vectoring-mode CORDIC cell of the central-angle chain.
`default_nettype none
module gcd_vec_cell #(
	parameter int STAGE = 0
) (
	input  logic                         clk,
	input  logic signed [gcd_pkg::XW-1:0] x_i,
	input  logic signed [gcd_pkg::XW-1:0] y_i,
	input  logic signed [gcd_pkg::XW-1:0] z_i,
	output logic signed [gcd_pkg::XW-1:0] x_q,
	output logic signed [gcd_pkg::XW-1:0] y_q,
	output logic signed [gcd_pkg::XW-1:0] z_q
);
	import gcd_pkg::*;

	localparam logic signed [XW-1:0] ANG = XW'(atan_q30(STAGE));

	always_ff @(posedge clk) begin
		if (!y_i[XW-1]) begin
			x_q <= x_i + (y_i >>> STAGE);
			y_q <= y_i - (x_i >>> STAGE);
			z_q <= z_i + ANG;
		end else begin
			x_q <= x_i - (y_i >>> STAGE);
			y_q <= y_i + (x_i >>> STAGE);
			z_q <= z_i - ANG;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/great_circle_distance_top.sv
// Haversine great-circle distance: fully pipelined CORDIC and square-root cell chains.
// Usage:
//   Input channel: a pair of points (lat_a, lon_a, lat_b, lon_b) is taken on any clock
//   edge where start is high; busy is held low, so one beat may enter every cycle.
//   Output channel: distance is valid for the single cycle that done is high.
//   The pipeline holds three input and conversion stages, the sine/cosine cell chain,
//   three multiply and sum stages, a 31-cell square-root chain, the vectoring cell
//   chain and two scaling stages.
//   Throughput is one beat per cycle; every stage is a register of its own.
//   Config: cfg_wr_en with cfg_wr_data sets radius_km; write only while no beat is
//   in flight. Reset sets radius_km to 6371 and clears the valid pipeline; the result
//   receiver cannot stall, results are simply presented once.
`default_nettype none
module great_circle_distance_top #(
	parameter int CORDIC_STAGES = 24,
	parameter int ANGLE_FRAC_BITS = 22
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [29:0] lat_a,
	input  logic signed [30:0] lon_a,
	input  logic signed [29:0] lat_b,
	input  logic signed [30:0] lon_b,
	output logic               done,
	output logic [25:0]        distance,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);
	import gcd_pkg::*;

	localparam int N = CORDIC_STAGES;
	localparam int SH = ANGLE_FRAC_BITS + 6;
	localparam int RW = 64 - SH + 1;
	localparam int ZW = (RW + 2 > 34) ? RW + 2 : 34;
	localparam int LAT = 2 * N + 39;
	localparam logic signed [ZW-1:0] ZPI = ZW'(Q30_PI);
	localparam logic signed [ZW-1:0] ZHPI = ZW'(Q30_HALF_PI);

	logic [15:0] radius_q;
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			vld_q <= '0;
		end else begin
			if (cfg_wr_en) radius_q <= cfg_wr_data;
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	// lanes: latitude a, latitude b, half latitude delta, half longitude delta
	logic signed [31:0] src_s1 [LANES];
	logic signed [RW-1:0] rad_s2 [LANES];
	logic signed [ZW-1:0] z_s3 [LANES];
	logic neg_s3 [LANES];

	always_ff @(posedge clk) begin
		src_s1[0] <= 32'(lat_a);
		src_s1[1] <= 32'(lat_b);
		src_s1[2] <= 32'(lat_b) - 32'(lat_a);
		src_s1[3] <= 32'(lon_b) - 32'(lon_a);
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (l < 2) rad_s2[l] <= RW'((64'(src_s1[l]) * 64'(DEG2RAD_Q36)) >>> SH);
			else rad_s2[l] <= RW'((64'(src_s1[l]) * 64'(DEG2RAD_Q36)) >>> (SH + 1));
		end
	end

	always_ff @(posedge clk) begin
		logic signed [ZW-1:0] z;
		logic n;
		for (int l = 0; l < LANES; l++) begin
			z = ZW'(rad_s2[l]);
			n = 1'b0;
			for (int r = 0; r < 2; r++) begin
				if (z > ZHPI) begin
					z = z - ZPI;
					n = !n;
				end else if (z < -ZHPI) begin
					z = z + ZPI;
					n = !n;
				end
			end
			z_s3[l] <= z;
			neg_s3[l] <= n;
		end
	end

	logic signed [XW-1:0] rx [LANES][N+1];
	logic signed [XW-1:0] ry [LANES][N+1];
	logic signed [ZW-1:0] rz [LANES][N+1];
	logic rn [LANES][N+1];

	for (genvar l = 0; l < LANES; l++) begin : g_rot
		assign rx[l][0] = Q30_GAIN;
		assign ry[l][0] = '0;
		assign rz[l][0] = z_s3[l];
		assign rn[l][0] = neg_s3[l];
		for (genvar i = 0; i < N; i++) begin : g_cell
			gcd_rot_cell #(.STAGE(i), .ZW(ZW)) u_cell (
				.clk  (clk),
				.x_i  (rx[l][i]),
				.y_i  (ry[l][i]),
				.z_i  (rz[l][i]),
				.neg_i(rn[l][i]),
				.x_q  (rx[l][i+1]),
				.y_q  (ry[l][i+1]),
				.z_q  (rz[l][i+1]),
				.neg_q(rn[l][i+1])
			);
		end
	end

	logic signed [XW-1:0] c1, c2;
	logic signed [XW-1:0] cc_s4, sll_s4, sdd_s4, sll_s5, t_s5;
	logic [SQW-1:0] va_s6, vb_s6;

	assign c1 = rn[0][N] ? -rx[0][N] : rx[0][N];
	assign c2 = rn[1][N] ? -rx[1][N] : rx[1][N];

	always_ff @(posedge clk) begin
		cc_s4 <= XW'((68'(c1) * 68'(c2)) >>> 30);
		sll_s4 <= XW'((68'(ry[2][N]) * 68'(ry[2][N])) >>> 30);
		sdd_s4 <= XW'((68'(ry[3][N]) * 68'(ry[3][N])) >>> 30);
	end

	always_ff @(posedge clk) begin
		t_s5 <= XW'((68'(cc_s4) * 68'(sdd_s4)) >>> 30);
		sll_s5 <= sll_s4;
	end

	always_ff @(posedge clk) begin
		logic signed [XW:0] a;
		logic [30:0] ua;
		a = (XW+1)'(sll_s5) + (XW+1)'(t_s5);
		if (a[XW]) ua = '0;
		else if (a > (XW+1)'(Q30_ONE)) ua = 31'(Q30_ONE);
		else ua = 31'(a);
		va_s6 <= {ua, 30'b0};
		vb_s6 <= {31'(Q30_ONE) - ua, 30'b0};
	end

	logic [SQW-1:0] sv [2][SQRT_STEPS+1];
	logic [SQW-1:0] sr [2][SQRT_STEPS+1];

	assign sv[0][0] = va_s6;
	assign sv[1][0] = vb_s6;
	for (genvar m = 0; m < 2; m++) begin : g_sqrt
		assign sr[m][0] = '0;
		for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
			gcd_sqrt_cell #(.K(k)) u_cell (
				.clk(clk),
				.v_i(sv[m][k]),
				.r_i(sr[m][k]),
				.v_q(sv[m][k+1]),
				.r_q(sr[m][k+1])
			);
		end
	end

	logic signed [XW-1:0] vx [N+1];
	logic signed [XW-1:0] vy [N+1];
	logic signed [XW-1:0] vz [N+1];

	assign vx[0] = XW'(sr[1][SQRT_STEPS][30:0]);
	assign vy[0] = XW'(sr[0][SQRT_STEPS][30:0]);
	assign vz[0] = '0;
	for (genvar i = 0; i < N; i++) begin : g_vec
		gcd_vec_cell #(.STAGE(i)) u_cell (
			.clk(clk),
			.x_i(vx[i]),
			.y_i(vy[i]),
			.z_i(vz[i]),
			.x_q(vx[i+1]),
			.y_q(vy[i+1]),
			.z_q(vz[i+1])
		);
	end

	logic [49:0] prod_f1;
	logic [25:0] distance_f2;

	always_ff @(posedge clk) begin
		logic [32:0] zu;
		zu = vz[N][XW-1] ? '0 : vz[N][32:0];
		prod_f1 <= 50'(zu) * 50'({radius_q, 1'b0});
	end

	always_ff @(posedge clk) begin
		logic [27:0] d;
		d = 28'((prod_f1 + 50'(1 << 21)) >> 22);
		distance_f2 <= (d > 28'(DIST_MAX)) ? DIST_MAX : d[25:0];
	end

	assign distance = distance_f2;
endmodule
`default_nettype wire
